// ----- hw/rtl/abp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package abp_pkg;

    // Moment store geometry (power of two: the element index is folded by truncation)
    localparam int ELEMENTS = 4096;
    localparam int ADDR_W   = $clog2(ELEMENTS);

    localparam int IDX_W    = 12;
    localparam int DATA_W   = 32;
    localparam int BETA_W   = 16;

    // Long divider: 41-bit operands, 41 quotient bits, capped at 2^40
    localparam int DIV_W      = 41;
    localparam int DIV_STEPS  = 41;
    // Square root of a 64-bit radicand, one result bit per stage
    localparam int SQRT_STEPS = 32;

    localparam logic [DATA_W-1:0] ONE_Q32 = 32'hFFFF_FFFF;
    localparam logic [DIV_W-1:0]  CAP40   = 41'h100_0000_0000;

    typedef enum logic [2:0] {
        REG_LEARNING_RATE = 3'd0,
        REG_BETA_ONE      = 3'd1,
        REG_BETA_TWO      = 3'd2,
        REG_EPSILON       = 3'd3,
        REG_DECAY_RATE    = 3'd4
    } cfg_reg_t;

    typedef enum logic {
        CMD_UPDATE   = 1'b0,
        CMD_END_STEP = 1'b1
    } cmd_t;

    // Queued item, classified by the front end
    typedef struct packed {
        logic                     eos;
        logic [IDX_W-1:0]         idx;
        logic signed [DATA_W-1:0] grad;
        logic signed [DATA_W-1:0] param;
    } q_item_t;

    typedef struct packed {
        logic    valid;
        q_item_t item;
    } q_head_t;

    typedef struct packed {
        logic pop;
        logic clearing;
    } back_ctl_t;

    // Side data that rides along the divider and root pipelines
    typedef struct packed {
        logic                   eos;
        logic [IDX_W-1:0]       idx;
        logic                   neg;
        logic signed [DATA_W:0] res0;
        logic [DIV_W-1:0]       mh;
    } tag_t;

    typedef struct packed {
        logic [DATA_W-1:0] learning_rate;
        logic [BETA_W-1:0] beta_one;
        logic [BETA_W-1:0] beta_two;
        logic [DATA_W-1:0] epsilon;
        logic [DATA_W-1:0] lr_decay;
        logic              decay_on;
    } cfg_t;

endpackage

`default_nettype wire

// ----- hw/rtl/abp_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module abp_front
    import abp_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic                     cmd,
    input  wire logic [IDX_W-1:0]         element_index,
    input  wire logic signed [DATA_W-1:0] gradient,
    input  wire logic signed [DATA_W-1:0] param_value,
    input  wire back_ctl_t                ctl,
    output q_head_t                       head
);

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    q_item_t            q_mem [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic               push;
    q_item_t            item_in;

    assign in_stall = (count_reg == QCNT_W'(QDEPTH)) || ctl.clearing;
    assign push     = in_valid && !in_stall;

    always_comb
    begin
        item_in.eos   = (cmd_t'(cmd) == CMD_END_STEP);
        item_in.idx   = element_index;
        item_in.grad  = gradient;
        item_in.param = param_value;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= item_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (ctl.pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !ctl.pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!push && ctl.pop)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.item  = q_mem[rd_ptr_reg];

endmodule

`default_nettype wire

// ----- hw/rtl/abp_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Pipelined restoring divider: quo = min(2^40, floor(num * 2^32 / den)), den >= 1
module abp_div
    import abp_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic             v_i,
    input  wire logic [DIV_W-1:0] num,
    input  wire logic [DIV_W-1:0] den,
    input  wire tag_t             tag_i,
    output logic                  v_o,
    output logic [DIV_W-1:0]      quo,
    output tag_t                  tag_o
);

    localparam int N = DIV_STEPS;

    logic             v_reg  [0:N];
    logic [DIV_W-1:0] r_reg  [0:N];
    logic [DIV_W-1:0] d_reg  [0:N];
    logic [DIV_W-1:0] b_reg  [0:N];
    logic [DIV_W-1:0] q_reg  [0:N];
    logic             ov_reg [0:N];
    tag_t             t_reg  [0:N];

    logic [DIV_W-1:0] r_next [1:N];
    logic [DIV_W-1:0] q_next [1:N];

    always_comb
    begin
        for (int k = 1; k <= N; k++)
        begin
            logic [DIV_W:0] t;
            logic           ge;
            t  = {r_reg[k-1], b_reg[k-1][DIV_W-1]};
            ge = (t >= {1'b0, d_reg[k-1]});
            r_next[k] = ge ? DIV_W'(t - {1'b0, d_reg[k-1]}) : t[DIV_W-1:0];
            q_next[k] = {q_reg[k-1][DIV_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= N; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            v_reg[0] <= v_i;
            for (int k = 1; k <= N; k++)
            begin
                v_reg[k] <= v_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // quotient would need more than 41 bits
            ov_reg[0] <= ({9'd0, num} >= {den, 9'd0});
            r_reg[0]  <= {9'd0, num[DIV_W-1:9]};
            b_reg[0]  <= {num[8:0], 32'd0};
            q_reg[0]  <= '0;
            d_reg[0]  <= den;
            t_reg[0]  <= tag_i;
            for (int k = 1; k <= N; k++)
            begin
                ov_reg[k] <= ov_reg[k-1];
                r_reg[k]  <= r_next[k];
                b_reg[k]  <= {b_reg[k-1][DIV_W-2:0], 1'b0};
                q_reg[k]  <= q_next[k];
                d_reg[k]  <= d_reg[k-1];
                t_reg[k]  <= t_reg[k-1];
            end
        end
    end

    assign v_o   = v_reg[N];
    assign tag_o = t_reg[N];
    assign quo   = (ov_reg[N] || (q_reg[N] > CAP40)) ? CAP40 : q_reg[N];

endmodule

`default_nettype wire

// ----- hw/rtl/abp_sqrt.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Pipelined integer square root, floor(sqrt(x)), two radicand bits per stage
module abp_sqrt
    import abp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        en,
    input  wire logic        v_i,
    input  wire logic [63:0] x_i,
    input  wire tag_t        tag_i,
    output logic             v_o,
    output logic [31:0]      root,
    output tag_t             tag_o
);

    localparam int N = SQRT_STEPS;

    logic        v_reg   [0:N];
    logic [63:0] x_reg   [0:N];
    logic [33:0] rem_reg [0:N];
    logic [31:0] res_reg [0:N];
    tag_t        t_reg   [0:N];

    logic [33:0] rem_next [1:N];
    logic [31:0] res_next [1:N];

    always_comb
    begin
        for (int k = 1; k <= N; k++)
        begin
            logic [35:0] t;
            logic [35:0] trial;
            logic        ge;
            t     = {rem_reg[k-1], x_reg[k-1][63:62]};
            trial = {2'b00, res_reg[k-1], 2'b01};
            ge    = (t >= trial);
            rem_next[k] = ge ? 34'(t - trial) : t[33:0];
            res_next[k] = {res_reg[k-1][30:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= N; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            v_reg[0] <= v_i;
            for (int k = 1; k <= N; k++)
            begin
                v_reg[k] <= v_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]   <= x_i;
            rem_reg[0] <= '0;
            res_reg[0] <= '0;
            t_reg[0]   <= tag_i;
            for (int k = 1; k <= N; k++)
            begin
                x_reg[k]   <= {x_reg[k-1][61:0], 2'b00};
                rem_reg[k] <= rem_next[k];
                res_reg[k] <= res_next[k];
                t_reg[k]   <= t_reg[k-1];
            end
        end
    end

    assign v_o   = v_reg[N];
    assign root  = res_reg[N];
    assign tag_o = t_reg[N];

endmodule

`default_nettype wire

// ----- hw/rtl/abp_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module abp_back
    import abp_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire cfg_t                 cfg,
    input  wire q_head_t              head,
    output back_ctl_t                 ctl,
    input  wire logic                 out_stall,
    output logic                      out_valid,
    output logic signed [DATA_W-1:0]  new_param,
    output logic [IDX_W-1:0]          result_index,
    output logic                      step_done
);

    logic en;
    logic pop;
    logic hazard;
    logic [ADDR_W-1:0] addr0;

    // clearing sweep
    logic              clr_busy_reg;
    logic [ADDR_W-1:0] clr_addr_reg;

    // moment stores
    logic [DATA_W-1:0] m_mem [ELEMENTS];
    logic [DATA_W-1:0] s_mem [ELEMENTS];
    logic [DATA_W-1:0] m_rd_reg;
    logic [DATA_W-1:0] s_rd_reg;

    // running powers
    logic [DATA_W-1:0] b1pow_reg;
    logic [DATA_W-1:0] b2pow_reg;
    logic [47:0]       np1_full;
    logic [47:0]       np2_full;
    logic [DATA_W-1:0] c1_next;
    logic [DATA_W-1:0] c2_next;

    // P1
    logic                     p1_v_reg, p1_eos_reg;
    logic [ADDR_W-1:0]        p1_addr_reg;
    logic [IDX_W-1:0]         p1_idx_reg;
    logic signed [DATA_W-1:0] p1_g_reg, p1_p_reg;
    logic [DATA_W-1:0]        p1_c1_reg, p1_c2_reg;
    logic [16:0]              omb1, omb2;
    logic signed [48:0]       pm1_next;
    logic signed [49:0]       pm2_next;
    logic signed [32:0]       rdiff;
    logic [32:0]              rmag_next;
    logic [DATA_W-1:0]        pmag;
    logic [63:0]              dprod_next;

    // P2
    logic                     p2_v_reg, p2_eos_reg;
    logic [ADDR_W-1:0]        p2_addr_reg;
    logic [IDX_W-1:0]         p2_idx_reg;
    logic signed [48:0]       p2_pm1_reg;
    logic signed [49:0]       p2_pm2_reg;
    logic [32:0]              p2_rmag_reg;
    logic [DATA_W-1:0]        p2_s_reg;
    logic [63:0]              p2_dprod_reg;
    logic signed [DATA_W-1:0] p2_p_reg;
    logic [DATA_W-1:0]        p2_c1_reg, p2_c2_reg;
    logic signed [50:0]       msum;
    logic [50:0]              mmag;
    logic [34:0]              mshift;
    logic [DATA_W-1:0]        m_new;
    logic [65:0]              rsq_full_next;
    logic [DATA_W-1:0]        dec;
    logic signed [DATA_W:0]   res0_next;
    logic                     m_we;

    // P3
    logic                     p3_v_reg, p3_eos_reg;
    logic [ADDR_W-1:0]        p3_addr_reg;
    logic [IDX_W-1:0]         p3_idx_reg;
    logic [DATA_W-1:0]        p3_m_reg;
    logic [65:0]              p3_rsq_reg;
    logic [DATA_W-1:0]        p3_s_reg;
    logic signed [DATA_W:0]   p3_res0_reg;
    logic [DATA_W-1:0]        p3_c1_reg, p3_c2_reg;
    logic [DATA_W-1:0]        rsq;
    logic [47:0]              ps1_next;
    logic [48:0]              ps2_next;

    // P4
    logic                     p4_v_reg, p4_eos_reg;
    logic [ADDR_W-1:0]        p4_addr_reg;
    logic [IDX_W-1:0]         p4_idx_reg;
    logic [47:0]              p4_ps1_reg;
    logic [48:0]              p4_ps2_reg;
    logic [DATA_W-1:0]        p4_mmag_reg;
    logic                     p4_neg_reg;
    logic signed [DATA_W:0]   p4_res0_reg;
    logic [DATA_W-1:0]        p4_c1_reg, p4_c2_reg;
    logic [49:0]              ssum;
    logic [DATA_W-1:0]        s_new;
    logic                     s_we;
    tag_t                     tag4;

    // divide / root chain
    logic             vm, vs, vr, vq;
    logic [DIV_W-1:0] q_m, q_s, q_r;
    tag_t             tag_s, tag_sq, tag_r, tag_q;
    logic [DIV_W-1:0] sh;
    logic [DIV_W-1:0] den_r;
    logic [DIV_W-1:0] den_sum;
    logic [31:0]      root;

    // final stages
    logic               f_v_reg;
    tag_t               f_tag_reg;
    logic [40:0]        f_ph_reg;
    logic [63:0]        f_pl_reg;
    logic [41:0]        step;
    logic signed [44:0] res_full;
    logic signed [DATA_W-1:0] res_sat;

    logic               out_valid_reg;
    logic signed [DATA_W-1:0] new_param_reg;
    logic [IDX_W-1:0]   result_index_reg;
    logic               step_done_reg;

    assign en    = !(out_valid_reg && out_stall);
    assign addr0 = ADDR_W'(head.item.idx);

    // a repeated element waits until the one ahead has written its moments back
    assign hazard = !head.item.eos && (
        (p1_v_reg && !p1_eos_reg && p1_addr_reg == addr0) ||
        (p2_v_reg && !p2_eos_reg && p2_addr_reg == addr0) ||
        (p3_v_reg && !p3_eos_reg && p3_addr_reg == addr0) ||
        (p4_v_reg && !p4_eos_reg && p4_addr_reg == addr0));

    assign pop          = head.valid && en && !clr_busy_reg && !hazard;
    assign ctl.pop      = pop;
    assign ctl.clearing = clr_busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == ADDR_W'(ELEMENTS - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // bias correction from the powers as they stand at issue
    assign np1_full = b1pow_reg * cfg.beta_one;
    assign np2_full = b2pow_reg * cfg.beta_two;

    always_comb
    begin
        c1_next = ONE_Q32 - np1_full[47:16];
        c2_next = ONE_Q32 - np2_full[47:16];
        if (c1_next == '0)
        begin
            c1_next = 32'd1;
        end
        if (c2_next == '0)
        begin
            c2_next = 32'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1pow_reg <= ONE_Q32;
            b2pow_reg <= ONE_Q32;
        end
        else if (pop && head.item.eos)
        begin
            b1pow_reg <= np1_full[47:16];
            b2pow_reg <= np2_full[47:16];
        end
    end

    // moment stores: cleared by the sweep, m written back from P2, s from P4
    assign m_we = en && p2_v_reg && !p2_eos_reg;
    assign s_we = en && p4_v_reg && !p4_eos_reg;

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            m_mem[clr_addr_reg] <= '0;
        end
        else if (m_we)
        begin
            m_mem[p2_addr_reg] <= m_new;
        end
        if (en)
        begin
            m_rd_reg <= m_mem[addr0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            s_mem[clr_addr_reg] <= '0;
        end
        else if (s_we)
        begin
            s_mem[p4_addr_reg] <= s_new;
        end
        if (en)
        begin
            s_rd_reg <= s_mem[addr0];
        end
    end

    // ---------------- P1 ----------------
    assign omb1 = 17'd65536 - {1'b0, cfg.beta_one};
    assign omb2 = 17'd65536 - {1'b0, cfg.beta_two};

    always_comb
    begin
        pm1_next   = $signed({1'b0, cfg.beta_one}) * $signed(m_rd_reg);
        pm2_next   = $signed({1'b0, omb1}) * p1_g_reg;
        rdiff      = {p1_g_reg[DATA_W-1], p1_g_reg} - {m_rd_reg[DATA_W-1], m_rd_reg};
        rmag_next  = rdiff[32] ? 33'(-rdiff) : 33'(rdiff);
        pmag       = p1_p_reg[DATA_W-1] ? DATA_W'(-p1_p_reg) : DATA_W'(p1_p_reg);
        dprod_next = pmag * cfg.lr_decay;
    end

    // ---------------- P2 ----------------
    always_comb
    begin
        msum   = 51'(p2_pm1_reg) + 51'(p2_pm2_reg);
        mmag   = msum[50] ? 51'(-msum) : 51'(msum);
        mshift = mmag[50:16];
        m_new  = msum[50] ? DATA_W'(-mshift) : DATA_W'(mshift);
        rsq_full_next = p2_rmag_reg * p2_rmag_reg;
        dec = p2_dprod_reg[63:32];
        if (!cfg.decay_on)
        begin
            res0_next = 33'(p2_p_reg);
        end
        else if (p2_p_reg[DATA_W-1])
        begin
            res0_next = 33'(p2_p_reg) + $signed({1'b0, dec});
        end
        else
        begin
            res0_next = 33'(p2_p_reg) - $signed({1'b0, dec});
        end
    end

    // ---------------- P3 ----------------
    always_comb
    begin
        rsq      = (|p3_rsq_reg[65:56]) ? ONE_Q32 : p3_rsq_reg[55:24];
        ps1_next = cfg.beta_two * p3_s_reg;
        ps2_next = omb2 * rsq;
    end

    // ---------------- P4 ----------------
    always_comb
    begin
        ssum  = 50'(p4_ps1_reg) + 50'(p4_ps2_reg);
        s_new = ssum[47:16];
        tag4.eos  = p4_eos_reg;
        tag4.idx  = p4_idx_reg;
        tag4.neg  = p4_neg_reg;
        tag4.res0 = p4_res0_reg;
        tag4.mh   = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_v_reg <= 1'b0;
            p2_v_reg <= 1'b0;
            p3_v_reg <= 1'b0;
            p4_v_reg <= 1'b0;
        end
        else if (en)
        begin
            p1_v_reg <= pop;
            p2_v_reg <= p1_v_reg;
            p3_v_reg <= p2_v_reg;
            p4_v_reg <= p3_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_eos_reg  <= head.item.eos;
            p1_addr_reg <= addr0;
            p1_idx_reg  <= head.item.idx;
            p1_g_reg    <= head.item.grad;
            p1_p_reg    <= head.item.param;
            p1_c1_reg   <= c1_next;
            p1_c2_reg   <= c2_next;

            p2_eos_reg   <= p1_eos_reg;
            p2_addr_reg  <= p1_addr_reg;
            p2_idx_reg   <= p1_idx_reg;
            p2_pm1_reg   <= pm1_next;
            p2_pm2_reg   <= pm2_next;
            p2_rmag_reg  <= rmag_next;
            p2_s_reg     <= s_rd_reg;
            p2_dprod_reg <= dprod_next;
            p2_p_reg     <= p1_p_reg;
            p2_c1_reg    <= p1_c1_reg;
            p2_c2_reg    <= p1_c2_reg;

            p3_eos_reg  <= p2_eos_reg;
            p3_addr_reg <= p2_addr_reg;
            p3_idx_reg  <= p2_idx_reg;
            p3_m_reg    <= m_new;
            p3_rsq_reg  <= rsq_full_next;
            p3_s_reg    <= p2_s_reg;
            p3_res0_reg <= res0_next;
            p3_c1_reg   <= p2_c1_reg;
            p3_c2_reg   <= p2_c2_reg;

            p4_eos_reg  <= p3_eos_reg;
            p4_addr_reg <= p3_addr_reg;
            p4_idx_reg  <= p3_idx_reg;
            p4_ps1_reg  <= ps1_next;
            p4_ps2_reg  <= ps2_next;
            p4_neg_reg  <= p3_m_reg[DATA_W-1];
            p4_mmag_reg <= p3_m_reg[DATA_W-1] ? DATA_W'(-p3_m_reg) : p3_m_reg;
            p4_res0_reg <= p3_res0_reg;
            p4_c1_reg   <= p3_c1_reg;
            p4_c2_reg   <= p3_c2_reg;
        end
    end

    // m_hat and s_hat side by side; the s lane carries the item
    abp_div u_div_m (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .v_i   (p4_v_reg),
        .num   ({9'd0, p4_mmag_reg}),
        .den   ({9'd0, p4_c1_reg}),
        .tag_i ('0),
        .v_o   (vm),
        .quo   (q_m),
        .tag_o ()
    );

    abp_div u_div_s (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .v_i   (p4_v_reg),
        .num   ({9'd0, s_new}),
        .den   ({9'd0, p4_c2_reg}),
        .tag_i (tag4),
        .v_o   (vs),
        .quo   (q_s),
        .tag_o (tag_s)
    );

    always_comb
    begin
        sh        = (q_s == CAP40) ? CAP40 - 1'b1 : q_s;
        tag_sq    = tag_s;
        tag_sq.mh = q_m;
    end

    abp_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .v_i   (vs && vm),
        .x_i   ({sh[39:0], 24'd0}),
        .tag_i (tag_sq),
        .v_o   (vr),
        .root  (root),
        .tag_o (tag_r)
    );

    always_comb
    begin
        den_sum = {1'b0, root, 8'd0} + {9'd0, cfg.epsilon};
        den_r   = (den_sum == '0) ? DIV_W'(1) : den_sum;
    end

    abp_div u_div_r (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .v_i   (vr),
        .num   (tag_r.mh),
        .den   (den_r),
        .tag_i (tag_r),
        .v_o   (vq),
        .quo   (q_r),
        .tag_o (tag_q)
    );

    // step = ratio * lr >> 32, split into high and low halves of the ratio
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_tag_reg <= tag_q;
            f_ph_reg  <= q_r[40:32] * cfg.learning_rate;
            f_pl_reg  <= q_r[31:0] * cfg.learning_rate;
        end
    end

    always_comb
    begin
        step = {1'b0, f_ph_reg} + 42'(f_pl_reg[63:32]);
        if (f_tag_reg.neg)
        begin
            res_full = 45'(f_tag_reg.res0) + $signed({3'b000, step});
        end
        else
        begin
            res_full = 45'(f_tag_reg.res0) - $signed({3'b000, step});
        end
        if (res_full > 45'sd2147483647)
        begin
            res_sat = 32'sh7FFF_FFFF;
        end
        else if (res_full < -45'sd2147483648)
        begin
            res_sat = 32'sh8000_0000;
        end
        else
        begin
            res_sat = DATA_W'(res_full);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_v_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            f_v_reg       <= vq;
            out_valid_reg <= f_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            new_param_reg    <= f_tag_reg.eos ? '0 : res_sat;
            result_index_reg <= f_tag_reg.idx;
            step_done_reg    <= f_tag_reg.eos;
        end
    end

    assign out_valid    = out_valid_reg;
    assign new_param    = new_param_reg;
    assign result_index = result_index_reg;
    assign step_done    = step_done_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/adabelief_param_update.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Direction | Handshake             | Payload
// in        | input     | in_valid / in_stall   | cmd, element_index, gradient, param_value
// out       | output    | out_valid / out_stall | new_param, result_index, step_done
// cfg       | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One item per cycle for distinct element indices while out_stall is low; an
// input transfer reaches out_valid through the four moment stages, the two
// 42-stage dividers and the 33-stage square root in series.
// An update to an element still in its moment read-modify-write (four stages)
// holds the queue until that write is done.
// After reset a clearing sweep zeroes both moment stores, with in_stall high
// throughout. Configuration is taken at any time (cfg_ready is tied high).
// out_stall with out_valid high freezes the whole back pipeline; the four-entry
// input queue keeps taking transfers until full.
module adabelief_param_update
    import abp_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,

    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic                     cmd,
    input  wire logic [IDX_W-1:0]         element_index,
    input  wire logic signed [DATA_W-1:0] gradient,
    input  wire logic signed [DATA_W-1:0] param_value,

    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic signed [DATA_W-1:0]      new_param,
    output logic [IDX_W-1:0]              result_index,
    output logic                          step_done,

    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [2:0]               cfg_index,
    input  wire logic [DATA_W-1:0]        cfg_data
);

    localparam logic [DATA_W-1:0] LR_RESET    = 32'd4294967;
    localparam logic [BETA_W-1:0] B1_RESET    = 16'd58982;
    localparam logic [BETA_W-1:0] B2_RESET    = 16'd65470;
    localparam logic [DATA_W-1:0] EPS_RESET   = 32'd43;
    localparam logic [BETA_W-1:0] DECAY_RESET = 16'd0;

    logic [DATA_W-1:0] lr_reg;
    logic [BETA_W-1:0] b1_reg;
    logic [BETA_W-1:0] b2_reg;
    logic [DATA_W-1:0] eps_reg;
    logic [BETA_W-1:0] wd_reg;
    logic [DATA_W-1:0] lw_reg;
    logic [47:0]       lw_next;
    logic              cfg_we;

    cfg_t      cfg;
    q_head_t   head;
    back_ctl_t ctl;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    // register file; out-of-range indices are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lr_reg  <= LR_RESET;
            b1_reg  <= B1_RESET;
            b2_reg  <= B2_RESET;
            eps_reg <= EPS_RESET;
            wd_reg  <= DECAY_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_LEARNING_RATE: lr_reg  <= cfg_data;
                REG_BETA_ONE:      b1_reg  <= cfg_data[BETA_W-1:0];
                REG_BETA_TWO:      b2_reg  <= cfg_data[BETA_W-1:0];
                REG_EPSILON:       eps_reg <= cfg_data;
                REG_DECAY_RATE:    wd_reg  <= cfg_data[BETA_W-1:0];
                default:           ;
            endcase
        end
    end

    // lr * wd in Q0.32, registered from the written values
    assign lw_next = lr_reg * wd_reg;

    always_ff @(posedge clk)
    begin
        lw_reg <= lw_next[47:16];
    end

    always_comb
    begin
        cfg.learning_rate = lr_reg;
        cfg.beta_one      = b1_reg;
        cfg.beta_two      = b2_reg;
        cfg.epsilon       = eps_reg;
        cfg.lr_decay      = lw_reg;
        cfg.decay_on      = (wd_reg != '0);
    end

    // front: queue and classify
    abp_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .element_index (element_index),
        .gradient      (gradient),
        .param_value   (param_value),
        .ctl           (ctl),
        .head          (head)
    );

    // back: moments, bias correction, divide, root, apply
    abp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .head         (head),
        .ctl          (ctl),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .new_param    (new_param),
        .result_index (result_index),
        .step_done    (step_done)
    );

    // nothing is taken in while the stores are being cleared
    a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.clearing |-> in_stall)
        else $error("transfer possible during clearing sweep");

    // nothing leaves the queue during the sweep
    a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.clearing |-> !ctl.pop)
        else $error("queue popped during clearing sweep");

    // an end-of-step result carries a zero parameter
    a_step_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && step_done) |-> (new_param == '0))
        else $error("end-of-step result with nonzero parameter");

    // a pop needs a queued item
    a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.pop |-> head.valid)
        else $error("pop from empty queue");

endmodule

`default_nettype wire
